>>> hw/rtl/cscan_pkg.sv
// Shared types and constants for the C-SCAN disk arm scheduler.
// Used by the request cell, the cell chain and the top level.
package cscan_pkg;

  localparam int TRACK_BITS       = 12;
  localparam int TOTAL_BITS       = 18;
  localparam int DEF_MAX_REQUESTS = 32;
  localparam int CFG_IDX_BITS     = 2;
  localparam int CFG_DATA_BITS    = TRACK_BITS;

  localparam logic [TRACK_BITS-1:0] TOP_TRACK_RESET = TRACK_BITS'(199);

  // Stream payload layout, lowest field first, padded to whole bytes.
  localparam int IN_DATA_BITS  = ((TRACK_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 3 * TRACK_BITS + TOTAL_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_USER_BITS = 3;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_RUN  = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    MOVE_SERVE = 2'd0,
    MOVE_EDGE  = 2'd1,
    MOVE_JUMP  = 2'd2
  } move_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_TRACK = 2'd0,
    CFG_SWEEP_DOWN  = 2'd1,
    CFG_TOP_TRACK   = 2'd2
  } cfg_index_t;

  // Commands broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic rot_left;
    logic rot_right;
    logic clear;
  } chain_cmd_t;

endpackage

>>> hw/rtl/cscan_cell.sv
// One cell of the sorted request chain: holds a track and a valid bit.
// Depends on cscan_pkg for the command struct and track width.
module cscan_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  cscan_pkg::chain_cmd_t          cmd,
  input  logic [cscan_pkg::TRACK_BITS-1:0] ins_track,
  input  logic [cscan_pkg::TRACK_BITS-1:0] left_val,
  input  logic                           left_gt,
  input  logic                           left_valid,
  input  logic [cscan_pkg::TRACK_BITS-1:0] right_val,
  input  logic                           right_valid,
  input  logic [cscan_pkg::TRACK_BITS-1:0] head_val,
  output logic [cscan_pkg::TRACK_BITS-1:0] val,
  output logic                           valid,
  output logic                           gt,
  output logic                           tail
);
  import cscan_pkg::*;

  // A cell at or past the insertion point takes the new track, or its
  // left neighbor's entry when that one also moves up.
  assign gt   = valid && (val > ins_track);
  assign tail = valid && !right_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.insert) begin
      valid <= valid | left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (gt || !valid) begin
        val <= left_gt ? left_val : ins_track;
      end
    end else if (cmd.rot_left) begin
      val <= tail ? head_val : right_val;
    end else if (cmd.rot_right) begin
      val <= left_val;
    end
  end

endmodule

>>> hw/rtl/cscan_chain.sv
// Row of request cells kept in ascending order, with rotation for the walk.
// Depends on cscan_pkg and cscan_cell.
module cscan_chain #(
  parameter int MAX_REQUESTS = cscan_pkg::DEF_MAX_REQUESTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cscan_pkg::chain_cmd_t            cmd,
  input  logic [cscan_pkg::TRACK_BITS-1:0] ins_track,
  output logic [cscan_pkg::TRACK_BITS-1:0] head_val,
  output logic [MAX_REQUESTS-1:0]          valid_vec
);
  import cscan_pkg::*;

  logic [TRACK_BITS-1:0] vals  [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] gts;
  logic [MAX_REQUESTS-1:0] tails;
  logic [TRACK_BITS-1:0] tail_val;

  // The tail flag is one-hot over the valid prefix, so an OR picks it.
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      tail_val = tail_val | (tails[i] ? vals[i] : '0);
    end
  end

  assign head_val = vals[0];

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    logic [TRACK_BITS-1:0] l_val;
    logic                  l_gt;
    logic                  l_valid;
    logic [TRACK_BITS-1:0] r_val;
    logic                  r_valid;

    if (i == 0) begin : g_first
      assign l_val   = tail_val;
      assign l_gt    = 1'b0;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_val   = vals[i-1];
      assign l_gt    = gts[i-1];
      assign l_valid = valid_vec[i-1];
    end

    if (i == MAX_REQUESTS - 1) begin : g_last
      assign r_val   = head_val;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_val   = vals[i+1];
      assign r_valid = valid_vec[i+1];
    end

    cscan_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .ins_track  (ins_track),
      .left_val   (l_val),
      .left_gt    (l_gt),
      .left_valid (l_valid),
      .right_val  (r_val),
      .right_valid(r_valid),
      .head_val   (head_val),
      .val        (vals[i]),
      .valid      (valid_vec[i]),
      .gt         (gts[i]),
      .tail       (tails[i])
    );
  end

endmodule

>>> hw/rtl/cscan_disk_arm_scheduler.sv
// C-SCAN disk arm scheduler: sorted request chain, run sequencer, output stage.
// Depends on cscan_pkg and cscan_chain.
//
//   channel   dir  beat contents
//   s_axis    in   tuser = kind, tdata = track
//   m_axis    out  tdata = from/to/distance/total, tuser = move kind/dropped,
//                  tlast = final move of the run
//   cfg       in   cfg_wr_en, cfg_index, cfg_data: one register write per cycle
//
// A load beat inserts the track in order into the cell chain; when the chain
// is full the track is dropped and the drop flag set. A run walks the chain
// twice by rotation, one cell per cycle while the output is not stalled, and
// holds the input off until it ends, sweeping down with one extra rotation up
// front. The walk pauses while the output register holds an untaken beat.
// Reset clears the chain's valid bits, the request count, the drop flag and
// the sequencer.
module cscan_disk_arm_scheduler #(
  parameter int MAX_REQUESTS = cscan_pkg::DEF_MAX_REQUESTS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cscan_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // [11:0] track
  input  logic                                s_axis_tuser,  // [0] kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [11:0] from_track, [23:12] to_track, [35:24] distance, [53:36] total_distance
  output logic [cscan_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic [cscan_pkg::OUT_USER_BITS-1:0] m_axis_tuser,  // [1:0] move_kind, [2] dropped
  output logic                                m_axis_tlast,
  input  logic                                cfg_wr_en,
  input  logic [cscan_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cscan_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import cscan_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_REQUESTS);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PREROT = 7'b0000010,
    ST_PASS1  = 7'b0000100,
    ST_EDGE   = 7'b0001000,
    ST_JUMP   = 7'b0010000,
    ST_PASS2  = 7'b0100000,
    ST_FLUSH  = 7'b1000000
  } seq_state_t;

  typedef struct packed {
    logic [TRACK_BITS-1:0] from_track;
    logic [TRACK_BITS-1:0] to_track;
    logic [TRACK_BITS-1:0] distance;
    move_kind_t            move_kind;
    logic [TOTAL_BITS-1:0] total_distance;
    logic                  dropped;
  } move_t;

  // Configuration registers.
  logic [TRACK_BITS-1:0] start_track;
  logic                  sweep_down;
  logic [TRACK_BITS-1:0] top_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_track <= '0;
      sweep_down  <= 1'b0;
      top_track   <= TOP_TRACK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_TRACK: start_track <= cfg_data[TRACK_BITS-1:0];
        CFG_SWEEP_DOWN:  sweep_down  <= cfg_data[0];
        CFG_TOP_TRACK:   top_track   <= cfg_data[TRACK_BITS-1:0];
        default: ;
      endcase
    end
  end

  seq_state_t            state;
  seq_state_t            state_next;
  logic [CNT_BITS-1:0]   cnt;
  logic [CNT_BITS-1:0]   step;
  logic                  overflow;
  logic [TRACK_BITS-1:0] pos;
  logic [TOTAL_BITS-1:0] run_total;
  move_t                 pend;
  logic                  pend_valid;
  move_t                 out_beat;
  logic                  out_last;
  logic                  out_valid;

  chain_cmd_t            cmd;
  logic [TRACK_BITS-1:0] head_val;
  logic [MAX_REQUESTS-1:0] valid_vec;

  logic [TRACK_BITS-1:0] in_track;
  logic [TRACK_BITS-1:0] ins_track;
  logic [TRACK_BITS-1:0] start_eff;
  logic                  in_fire;
  logic                  adv;
  logic                  pass_done;
  logic                  head_hit;
  logic                  gen;
  logic [TRACK_BITS-1:0] gen_from;
  logic [TRACK_BITS-1:0] gen_to;
  move_kind_t            gen_kind;
  logic [TRACK_BITS-1:0] gen_dist;
  logic [TOTAL_BITS-1:0] gen_total;
  logic                  push;

  assign in_track  = s_axis_tdata[TRACK_BITS-1:0];
  assign ins_track = (in_track > top_track) ? top_track : in_track;
  assign start_eff = (start_track > top_track) ? top_track : start_track;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign adv           = !out_valid || m_axis_tready;
  assign pass_done     = (step == cnt);

  cscan_chain #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .ins_track(ins_track),
    .head_val (head_val),
    .valid_vec(valid_vec)
  );

  // Which stored tracks a pass serves depends on direction and pass.
  always_comb begin
    if (state == ST_PASS1) begin
      head_hit = sweep_down ? (head_val <= start_eff) : (head_val >= start_eff);
    end else begin
      head_hit = sweep_down ? (head_val > start_eff) : (head_val < start_eff);
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    gen           = 1'b0;
    gen_from      = pos;
    gen_to        = head_val;
    gen_kind      = MOVE_SERVE;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (item_kind_t'(s_axis_tuser) == KIND_RUN) begin
            state_next = sweep_down ? ST_PREROT : ST_PASS1;
          end else if (cnt != MAX_CNT) begin
            cmd.insert = 1'b1;
          end
        end
      end
      ST_PREROT: begin
        if (adv) begin
          cmd.rot_right = 1'b1;
          state_next    = ST_PASS1;
        end
      end
      ST_PASS1, ST_PASS2: begin
        if (adv) begin
          if (pass_done) begin
            state_next = (state == ST_PASS1) ? ST_EDGE : ST_FLUSH;
          end else begin
            gen           = head_hit;
            cmd.rot_left  = !sweep_down;
            cmd.rot_right = sweep_down;
          end
        end
      end
      ST_EDGE: begin
        gen_to = sweep_down ? '0 : top_track;
        if (adv) begin
          gen        = (pos != gen_to);
          gen_kind   = MOVE_EDGE;
          state_next = ST_JUMP;
        end
      end
      ST_JUMP: begin
        gen_from = sweep_down ? '0 : top_track;
        gen_to   = sweep_down ? top_track : '0;
        gen_kind = MOVE_JUMP;
        if (adv) begin
          gen        = 1'b1;
          state_next = ST_PASS2;
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (gen_kind == MOVE_JUMP) begin
      gen_dist = top_track;
    end else if (gen_from > gen_to) begin
      gen_dist = gen_from - gen_to;
    end else begin
      gen_dist = gen_to - gen_from;
    end
  end

  assign gen_total = run_total + TOTAL_BITS'(gen_dist);
  assign push      = (gen && pend_valid) || (state == ST_FLUSH && adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      overflow   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.insert) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.clear) begin
        cnt <= '0;
      end
      if (in_fire && item_kind_t'(s_axis_tuser) == KIND_LOAD && cnt == MAX_CNT) begin
        overflow <= 1'b1;
      end else if (cmd.clear) begin
        overflow <= 1'b0;
      end
      if (gen) begin
        pend_valid <= 1'b1;
      end else if (cmd.clear) begin
        pend_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= push;
      end
    end
  end

  // Run datapath: arm position, running total, step count and the beat held
  // back until the next move shows whether it is the final one.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos       <= start_eff;
      run_total <= '0;
      step      <= '0;
    end else begin
      if (cmd.rot_left || (cmd.rot_right && state != ST_PREROT)) begin
        step <= step + 1'b1;
      end else if (state == ST_JUMP) begin
        step <= '0;
      end
      if (gen) begin
        pos                 <= gen_to;
        run_total           <= gen_total;
        pend.from_track     <= gen_from;
        pend.to_track       <= gen_to;
        pend.distance       <= gen_dist;
        pend.move_kind      <= gen_kind;
        pend.total_distance <= gen_total;
        pend.dropped        <= overflow;
      end
    end
    if (adv && push) begin
      out_beat <= pend;
      out_last <= (state == ST_FLUSH);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_BITS'({out_beat.total_distance, out_beat.distance,
                                         out_beat.to_track, out_beat.from_track});
  assign m_axis_tuser  = {out_beat.dropped, out_beat.move_kind};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_cnt_matches_chain: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(cnt))
    else $error("request count disagrees with the chain's valid cells");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt <= MAX_CNT)
    else $error("request count above capacity");

  a_jump_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PASS2 || state == ST_FLUSH) |-> pend_valid)
    else $error("no pending move after the wrap jump");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && adv) |=> (m_axis_tvalid && m_axis_tlast && state == ST_IDLE))
    else $error("run end did not present the final beat");
`endif

endmodule
